FILE: src/i2cms_pkg.sv
// Shared types and op codes for the I2C master bit sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package i2cms_pkg;

  // Request op codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_SACK  = 3'd5;
  localparam logic [2:0] OP_RACK  = 3'd6;

  // Last phase indexes of the byte commands
  localparam logic [4:0] WRITE_LAST_PHASE = 5'd23;
  localparam logic [4:0] READ_LAST_PHASE  = 5'd24;

  // Sub-phase codes of a three-phase clocked bit
  localparam logic [1:0] SUB_SET  = 2'd0;
  localparam logic [1:0] SUB_MID  = 2'd1;
  localparam logic [1:0] SUB_LAST = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       sda_in;
  } i2cms_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_read;
    logic       rejected;
  } i2cms_out_t;

endpackage

`default_nettype wire

FILE: src/i2cms_seq.sv
// Command latch and phase sequencer: pin levels, shift byte and phase counters.
// Depends on i2cms_pkg; steps once for each request taken from the input register.
`default_nettype none

module i2cms_seq
  import i2cms_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             step,
  input  i2cms_in_t       item,
  output i2cms_out_t      res
);

  logic [4:0] phase_r,  phase_nxt;
  logic [1:0] sub_r,    sub_nxt;
  logic [2:0] cmd_r,    cmd_nxt;
  logic [7:0] shift_r,  shift_nxt;
  logic [7:0] held_r,   held_nxt;
  logic       scl_r,    scl_nxt;
  logic       sda_r,    sda_nxt;
  logic       ack_r,    ack_nxt;
  logic       is_cmd;
  logic       busy;
  logic       last;
  logic       done;
  logic       rej;

  assign is_cmd = (item.op >= OP_START) && (item.op <= OP_RACK);
  assign busy   = (cmd_r != OP_TICK);

  // Latch a command or run one phase of the active one
  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    cmd_nxt   = cmd_r;
    shift_nxt = shift_r;
    held_nxt  = held_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    last      = 1'b0;
    done      = 1'b0;
    rej       = 1'b0;
    if (step) begin
      if (is_cmd) begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          cmd_nxt   = item.op;
          phase_nxt = '0;
          sub_nxt   = SUB_SET;
          if (item.op == OP_WRITE || item.op == OP_SACK) begin
            shift_nxt = item.data;
          end else if (item.op == OP_READ) begin
            shift_nxt = '0;
          end
        end
      end else if (busy) begin
        unique case (cmd_r)
          OP_START: begin
            if (phase_r == 5'd0) sda_nxt = 1'b1;
            else if (phase_r == 5'd1) scl_nxt = 1'b1;
            else if (phase_r == 5'd2) sda_nxt = 1'b0;
            else begin
              scl_nxt = 1'b0;
              last    = 1'b1;
            end
          end
          OP_STOP: begin
            if (phase_r == 5'd0) sda_nxt = 1'b0;
            else if (phase_r == 5'd1) scl_nxt = 1'b1;
            else begin
              sda_nxt = 1'b1;
              last    = 1'b1;
            end
          end
          OP_WRITE: begin
            if (sub_r == SUB_SET) begin
              sda_nxt   = shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
            end else if (sub_r == SUB_MID) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
              last    = (phase_r >= WRITE_LAST_PHASE);
            end
          end
          OP_READ: begin
            if (phase_r == 5'd0) begin
              sda_nxt = 1'b1;
            end else if (sub_r == SUB_SET) begin
              scl_nxt = 1'b1;
            end else if (sub_r == SUB_MID) begin
              shift_nxt = {shift_r[6:0], item.sda_in};
            end else begin
              scl_nxt = 1'b0;
              if (phase_r >= READ_LAST_PHASE) begin
                held_nxt = shift_r;
                last     = 1'b1;
              end
            end
          end
          OP_SACK: begin
            if (phase_r == 5'd0) sda_nxt = shift_r[0];
            else if (phase_r == 5'd1) scl_nxt = 1'b1;
            else begin
              scl_nxt = 1'b0;
              last    = 1'b1;
            end
          end
          OP_RACK: begin
            if (phase_r == 5'd0) sda_nxt = 1'b1;
            else if (phase_r == 5'd1) scl_nxt = 1'b1;
            else if (phase_r == 5'd2) ack_nxt = item.sda_in;
            else begin
              scl_nxt = 1'b0;
              last    = 1'b1;
            end
          end
          default: last = 1'b1;
        endcase
        // Advance the phase and the three-phase bit position
        phase_nxt = phase_r + 5'd1;
        if (!(cmd_r == OP_READ && phase_r == 5'd0)) begin
          sub_nxt = (sub_r == SUB_LAST) ? SUB_SET : sub_r + 2'd1;
        end
        if (last) begin
          done      = 1'b1;
          cmd_nxt   = OP_TICK;
          phase_nxt = '0;
        end
      end
    end
  end

  // Hold sequencer state; lines reset released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      sub_r   <= SUB_SET;
      cmd_r   <= OP_TICK;
      shift_r <= '0;
      held_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      cmd_r   <= cmd_nxt;
      shift_r <= shift_nxt;
      held_r  <= held_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
    end
  end

  // Build the result from the updated state
  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (cmd_nxt != OP_TICK);
    res.done_res  = done;
    res.read_byte = held_nxt;
    res.ack_read  = ack_nxt;
    res.rejected  = rej;
  end

endmodule

`default_nettype wire

FILE: src/i2c_master_bit_sequencer.sv
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while out_ready does not stall the result;
// each tick moves one bus phase, so a byte takes 24 or 25 ticks. Reset (rst_n
// low, synchronous) empties both registers, goes idle and releases SCL and SDA.
// Top level of the I2C master bit sequencer; depends on i2cms_pkg and i2cms_seq.
`default_nettype none

module i2c_master_bit_sequencer
  import i2cms_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  i2cms_in_t  in_item,
  output logic       out_valid,
  input  wire        out_ready,
  output i2cms_out_t out_item
);

  logic       in_valid_r;
  i2cms_in_t  in_item_r;
  i2cms_out_t res;
  logic       advance;

  // Move the held request into the sequencer when the result slot frees up
  assign advance  = in_valid_r && (!out_valid || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  i2cms_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .res   (res)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

FILE: src/i2cms_checker.sv
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends on i2cms_pkg and i2c_master_bit_sequencer.
`default_nettype none

module i2cms_checker
  import i2cms_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input i2cms_out_t out_item
);

  // Drop valid only after the result is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Stall the input only while a result waits to be taken
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with the result side free");

  // A finished command leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.done_res |-> !out_item.busy_res)
    else $error("done with busy still set");

  // A rejected request only happens while busy, and never finishes a command
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.rejected |-> out_item.busy_res && !out_item.done_res)
    else $error("rejected request while idle or done");

  // Come out of reset with no result pending
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for the I2C master bit sequencer: queued requests drive SCL/SDA
// command sequences, and a bus-level model predicts every result.
// Depends on i2cms_pkg and the i2c_master_bit_sequencer RTL.
module tb_top;
  import i2cms_pkg::*;

  localparam int RANDOM_REQS    = 800;
  localparam int IDLE_LIMIT     = 2000;
  localparam int PRESSURE_AT    = 150;
  localparam int PRESSURE_HOLD  = 300;
  localparam int DRAIN_CYCLES   = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  i2cms_in_t  in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  i2cms_out_t out_item;

  // Pending requests and the pin states they should produce
  i2cms_in_t  bus_reqs[$];
  i2cms_out_t expected_pins[$];

  // Bus model state, at reset values
  logic [4:0] m_phase = '0;
  logic [2:0] m_cmd = OP_TICK;
  logic [7:0] m_shift = '0;
  logic       m_scl = 1'b1;
  logic       m_sda = 1'b1;
  logic       m_ack = 1'b0;
  logic [7:0] m_rd_byte = '0;

  int total_reqs = 0;
  int reqs_accepted = 0;
  int results_seen = 0;
  int done_seen = 0;
  int rejects_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  i2c_master_bit_sequencer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the bus model by one request and return the expected pin state
  task automatic advance_bus_model(input i2cms_in_t req, output i2cms_out_t res);
    logic       last;
    logic       done;
    logic       rej;
    logic [4:0] p;
    logic [4:0] q;
    logic [1:0] sub;
    last = 1'b0;
    done = 1'b0;
    rej  = 1'b0;
    p    = m_phase;
    if (req.op >= OP_START && req.op <= OP_RACK) begin
      // a command while a sequence runs is dropped
      if (m_cmd != OP_TICK) begin
        rej = 1'b1;
      end else begin
        m_cmd   = req.op;
        m_phase = '0;
        if (req.op == OP_WRITE || req.op == OP_SACK) m_shift = req.data;
        else if (req.op == OP_READ) m_shift = '0;
      end
    end else if (m_cmd != OP_TICK) begin
      case (m_cmd)
        OP_START: begin
          if (p == 0) m_sda = 1'b1;
          else if (p == 1) m_scl = 1'b1;
          else if (p == 2) m_sda = 1'b0;
          else begin
            m_scl = 1'b0;
            last = 1'b1;
          end
        end
        OP_STOP: begin
          if (p == 0) m_sda = 1'b0;
          else if (p == 1) m_scl = 1'b1;
          else begin
            m_sda = 1'b1;
            last = 1'b1;
          end
        end
        OP_WRITE: begin
          sub = 2'(p % 3);
          case (sub)
            SUB_SET: begin
              m_sda   = m_shift[7];
              m_shift = {m_shift[6:0], 1'b0};
            end
            SUB_MID: m_scl = 1'b1;
            default: begin
              m_scl = 1'b0;
              if (p >= WRITE_LAST_PHASE) last = 1'b1;
            end
          endcase
        end
        OP_READ: begin
          if (p == 0) begin
            m_sda = 1'b1;
          end else begin
            q   = p - 5'd1;
            sub = 2'(q % 3);
            case (sub)
              SUB_SET: m_scl = 1'b1;
              SUB_MID: m_shift = {m_shift[6:0], req.sda_in};
              default: begin
                m_scl = 1'b0;
                if (p >= READ_LAST_PHASE) begin
                  m_rd_byte = m_shift;
                  last = 1'b1;
                end
              end
            endcase
          end
        end
        OP_SACK: begin
          if (p == 0) m_sda = m_shift[0];
          else if (p == 1) m_scl = 1'b1;
          else begin
            m_scl = 1'b0;
            last = 1'b1;
          end
        end
        OP_RACK: begin
          if (p == 0) m_sda = 1'b1;
          else if (p == 1) m_scl = 1'b1;
          else if (p == 2) m_ack = req.sda_in;
          else begin
            m_scl = 1'b0;
            last = 1'b1;
          end
        end
        default: last = 1'b1;
      endcase
      m_phase = p + 5'd1;
      if (last) begin
        done    = 1'b1;
        m_cmd   = OP_TICK;
        m_phase = '0;
      end
    end
    res.scl_out   = m_scl;
    res.sda_out   = m_sda;
    res.busy_res  = (m_cmd != OP_TICK);
    res.done_res  = done;
    res.read_byte = m_rd_byte;
    res.ack_read  = m_ack;
    res.rejected  = rej;
  endtask

  // Ticks needed to finish each command
  function automatic int phases_of(logic [2:0] op);
    case (op)
      OP_START: return 4;
      OP_STOP:  return 3;
      OP_WRITE: return 24;
      OP_READ:  return 25;
      OP_SACK:  return 3;
      OP_RACK:  return 4;
      default:  return 0;
    endcase
  endfunction

  // Mostly short gaps, a few long ones; every third stretch of 128 requests runs gap-free
  function automatic int pick_gap(int progress);
    int r;
    if ((progress / 128) % 3 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_req(logic [2:0] op, logic [7:0] data, logic sda);
    i2cms_in_t r;
    r.op     = op;
    r.data   = data;
    r.sda_in = sda;
    bus_reqs.push_back(r);
  endtask

  // Queue a command followed by its ticks; ticks sometimes use the spare op code,
  // and a stray command may land in the middle of the sequence
  task automatic push_cmd_seq(logic [2:0] op, logic [7:0] data, int n_ticks, bit strays);
    logic [2:0] tick_op;
    push_req(op, data, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n_ticks; i++) begin
      if (strays && $urandom_range(0, 19) == 0)
        push_req(3'($urandom_range(OP_START, OP_RACK)), 8'($urandom), 1'($urandom_range(0, 1)));
      tick_op = ($urandom_range(0, 9) == 0) ? 3'd7 : OP_TICK;
      push_req(tick_op, 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: hold each request until taken, then move to the next after a gap
  always @(posedge clk) begin : driver
    i2cms_out_t pred;
    int src_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_bus_model(in_item, pred);
        expected_pins.push_back(pred);
        reqs_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (bus_reqs.size() != 0) begin
          in_item  <= bus_reqs.pop_front();
          in_valid <= 1'b1;
          src_gap = pick_gap(reqs_accepted);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, stall at random
  always @(posedge clk) begin : monitor
    i2cms_out_t want;
    int stall_left;
    int hold_left;
    bit held_off;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      held_off   = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_item.done_res) done_seen++;
        if (out_item.rejected) rejects_seen++;
        if (expected_pins.size() == 0) begin
          $display("%0t: result with no request pending, expected none, got %h",
                   $time, out_item);
          mismatches++;
        end else begin
          want = expected_pins.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(out_item.scl_out));
          check_field("sda_out", 8'(want.sda_out), 8'(out_item.sda_out));
          check_field("busy_res", 8'(want.busy_res), 8'(out_item.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_item.done_res));
          check_field("read_byte", want.read_byte, out_item.read_byte);
          check_field("ack_read", 8'(want.ack_read), 8'(out_item.ack_read));
          check_field("rejected", 8'(want.rejected), 8'(out_item.rejected));
        end
      end
      // hold off once for a long stretch so the block backs up
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_off && results_seen >= PRESSURE_AT) begin
        held_off  = 1'b1;
        hold_left = PRESSURE_HOLD;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap(results_seen + 64);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n_directed;
    int r;
    int n_ticks;
    logic [2:0] op;
    logic [7:0] data;

    // Directed: idle tick, spare op code while idle, start with a command refused mid-way
    push_req(OP_TICK, 8'hFF, 1'b1);
    push_req(3'd7, 8'h00, 1'b0);
    push_req(OP_START, 8'h00, 1'b0);
    push_req(OP_TICK, 8'h00, 1'b0);
    push_req(OP_WRITE, 8'hFF, 1'b1);
    push_req(OP_TICK, 8'hFF, 1'b1);
    push_req(OP_TICK, 8'h00, 1'b0);
    push_req(OP_TICK, 8'hFF, 1'b1);
    push_cmd_seq(OP_STOP, 8'h00, 3, 1'b0);
    push_cmd_seq(OP_SACK, 8'h01, 3, 1'b0);
    push_cmd_seq(OP_SACK, 8'hFE, 3, 1'b0);
    push_cmd_seq(OP_RACK, 8'hFF, 4, 1'b0);
    n_directed = bus_reqs.size();

    // Random: mostly complete command sequences, some cut short, some noise
    while (bus_reqs.size() < n_directed + RANDOM_REQS) begin
      r = $urandom_range(0, 99);
      if (r < 88) begin
        op = 3'($urandom_range(OP_START, OP_RACK));
        case ($urandom_range(0, 9))
          0: data = 8'h00;
          1: data = 8'hFF;
          default: data = 8'($urandom);
        endcase
        n_ticks = phases_of(op);
        if ($urandom_range(0, 9) == 0) n_ticks = $urandom_range(0, n_ticks);
        push_cmd_seq(op, data, n_ticks, 1'b1);
      end else begin
        push_req(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    total_reqs = bus_reqs.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every request taken, every result seen, then idle before the summary
    while (reqs_accepted < total_reqs) @(posedge clk);
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d directed), checked %0d results.",
             total_reqs, n_directed, results_seen);
    $display("Saw %0d completed commands and %0d refused commands; %0d mismatches.",
             done_seen, rejects_seen, mismatches);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: i2c_master_bit_sequencer.f
src/i2cms_pkg.sv
src/i2cms_seq.sv
src/i2c_master_bit_sequencer.sv
src/i2cms_checker.sv
tb/sv/tb_top.sv
